[rtl/core/bqx_pkg.sv]
// Shared types and constants for the biquadratic exchange field accumulator.
`default_nettype none

package bqx_pkg;

  localparam int MaxAtoms = 4096;
  localparam int MaxTypes = 16;

  localparam int IdxW   = 12;
  localparam int TypeW  = 4;
  localparam int SpinW  = 16;
  localparam int CoupW  = 32;
  localparam int FieldW = 48;

  localparam logic [1:0] ACT_SPIN = 2'd0;
  localparam logic [1:0] ACT_COUP = 2'd1;
  localparam logic [1:0] ACT_PAIR = 2'd2;

  typedef logic signed [SpinW-1:0]  spin_t;
  typedef logic signed [CoupW-1:0]  coup_t;
  typedef logic signed [FieldW-1:0] field_t;

  typedef struct packed {
    spin_t x;
    spin_t y;
    spin_t z;
  } spin_vec_t;

  typedef struct packed {
    field_t x;
    field_t y;
    field_t z;
  } field_vec_t;

  typedef struct packed {
    logic            fire;
    logic            last;
    logic [IdxW-1:0] atom;
  } acc_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/bqx_spin_store.sv]
// Spin vector memory: one write port, two registered read ports.
`default_nettype none

module bqx_spin_store #(
  parameter int MAX_ATOMS = bqx_pkg::MaxAtoms,
  parameter int AW        = $clog2(MAX_ATOMS)
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [AW-1:0]            waddr,
  input  wire bqx_pkg::spin_vec_t wdata,
  input  wire                     re,
  input  wire [AW-1:0]            raddr_a,
  input  wire [AW-1:0]            raddr_b,
  output bqx_pkg::spin_vec_t      rdata_a,
  output bqx_pkg::spin_vec_t      rdata_b
);

  bqx_pkg::spin_vec_t mem [MAX_ATOMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[rtl/core/bqx_coup_store.sv]
// Exchange constant table: one write port, one registered read port.
`default_nettype none

module bqx_coup_store #(
  parameter int MAX_TYPES = bqx_pkg::MaxTypes,
  parameter int AW        = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [AW-1:0]        waddr,
  input  wire bqx_pkg::coup_t wdata,
  input  wire                 re,
  input  wire [AW-1:0]        raddr,
  output bqx_pkg::coup_t      rdata
);

  bqx_pkg::coup_t mem [MAX_TYPES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/bqx_term_pipe.sv]
// Four-stage multiply pipeline: floor(2*J*Sj*(Si.Sj)) in Q24.24 per component.
`default_nettype none

module bqx_term_pipe (
  input  wire                     clk,
  input  wire bqx_pkg::spin_vec_t si,
  input  wire bqx_pkg::spin_vec_t sj,
  input  wire bqx_pkg::coup_t     jc,
  output bqx_pkg::field_vec_t     term
);

  localparam int PdW  = 2 * bqx_pkg::SpinW;
  localparam int AW   = bqx_pkg::CoupW + bqx_pkg::SpinW;
  localparam int DotW = PdW + 1;
  localparam int DhW  = DotW - 16;
  localparam int HiW  = AW + DhW;
  localparam int LoW  = AW + 17;
  localparam int Frac = 36;
  localparam int SumW = Frac + bqx_pkg::FieldW;

  typedef logic signed [AW-1:0]  a_t;
  typedef logic signed [HiW-1:0] hi_t;
  typedef logic signed [LoW-1:0] lo_t;

  logic signed [PdW-1:0]  pd_x, pd_y, pd_z;
  a_t                     a1_x, a1_y, a1_z;
  a_t                     a2_x, a2_y, a2_z;
  logic signed [DotW-1:0] dot;
  logic signed [DhW-1:0]  dh;
  logic signed [16:0]     dl;
  hi_t                    hi_x, hi_y, hi_z;
  lo_t                    lo_x, lo_y, lo_z;
  logic signed [SumW-1:0] s_x, s_y, s_z;

  assign dh = dot[DotW-1:16];
  assign dl = $signed({1'b0, dot[15:0]});

  assign s_x = (SumW'(hi_x) <<< 16) + SumW'(lo_x);
  assign s_y = (SumW'(hi_y) <<< 16) + SumW'(lo_y);
  assign s_z = (SumW'(hi_z) <<< 16) + SumW'(lo_z);

  always_ff @(posedge clk) begin
    pd_x <= si.x * sj.x;
    pd_y <= si.y * sj.y;
    pd_z <= si.z * sj.z;
    a1_x <= jc * sj.x;
    a1_y <= jc * sj.y;
    a1_z <= jc * sj.z;

    dot  <= DotW'(pd_x) + DotW'(pd_y) + DotW'(pd_z);
    a2_x <= a1_x;
    a2_y <= a1_y;
    a2_z <= a1_z;

    hi_x <= a2_x * dh;
    hi_y <= a2_y * dh;
    hi_z <= a2_z * dh;
    lo_x <= a2_x * dl;
    lo_y <= a2_y * dl;
    lo_z <= a2_z * dl;

    term.x <= s_x[Frac +: bqx_pkg::FieldW];
    term.y <= s_y[Frac +: bqx_pkg::FieldW];
    term.z <= s_z[Frac +: bqx_pkg::FieldW];
  end

endmodule

`default_nettype wire

[rtl/core/bqx_accum.sv]
// Saturating field accumulators and the result output register.
`default_nettype none

module bqx_accum (
  input  wire                        clk,
  input  wire                        rst,
  input  wire bqx_pkg::acc_ctrl_t    ctrl,
  input  wire bqx_pkg::field_vec_t   term,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [bqx_pkg::IdxW-1:0]   out_atom,
  output bqx_pkg::field_vec_t        out_field
);

  localparam int W = bqx_pkg::FieldW;

  bqx_pkg::field_vec_t sum;
  bqx_pkg::field_vec_t sum_next;

  function automatic bqx_pkg::field_t sat_add(bqx_pkg::field_t a, bqx_pkg::field_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return s[W-1:0];
  endfunction

  assign sum_next.x = sat_add(sum.x, term.x);
  assign sum_next.y = sat_add(sum.y, term.y);
  assign sum_next.z = sat_add(sum.z, term.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.fire) begin
        sum <= ctrl.last ? '0 : sum_next;
      end
      if (ctrl.fire && ctrl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.last) begin
      out_atom  <= ctrl.atom;
      out_field <= sum_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/biquadratic_exchange_field_accumulator_top.sv]
// Top level: input sequencer, spin and coupling stores, term pipeline, accumulators.
// Spin and coupling loads keep the sequencer idle; the next word may follow at once.
// A pair word passes through a registered store read, four multiply stages and the accumulate step.
// A new pair word is not accepted until the previous one is accumulated, which a held output can delay.
// A last pair's result is registered when its accumulate step fires; the next word may enter while it is shown.
// Reset clears the sequencer, accumulators and output valid; stores hold until written.
`default_nettype none

module biquadratic_exchange_field_accumulator_top #(
  parameter int MAX_ATOMS = bqx_pkg::MaxAtoms,
  parameter int MAX_TYPES = bqx_pkg::MaxTypes
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       action,
  input  wire  [bqx_pkg::IdxW-1:0]         atom_index,
  input  wire  [bqx_pkg::IdxW-1:0]         neighbour_index,
  input  wire  [bqx_pkg::TypeW-1:0]        type_index,
  input  wire  signed [bqx_pkg::SpinW-1:0] spin_x,
  input  wire  signed [bqx_pkg::SpinW-1:0] spin_y,
  input  wire  signed [bqx_pkg::SpinW-1:0] spin_z,
  input  wire  signed [bqx_pkg::CoupW-1:0] coupling,
  input  wire                              last_neighbour,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [bqx_pkg::IdxW-1:0]         field_atom,
  output logic signed [bqx_pkg::FieldW-1:0] field_x,
  output logic signed [bqx_pkg::FieldW-1:0] field_y,
  output logic signed [bqx_pkg::FieldW-1:0] field_z
);

  localparam int ATOM_AW = $clog2(MAX_ATOMS);
  localparam int TYPE_AW = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] cnt;

  logic accept;
  logic atom_ok;
  logic nbr_ok;
  logic type_ok;
  logic pair_go;

  logic                     i_ok;
  logic                     j_ok;
  logic                     t_ok;
  logic                     last;
  logic [bqx_pkg::IdxW-1:0] atom;

  bqx_pkg::spin_vec_t  spin_wdata;
  bqx_pkg::spin_vec_t  rd_i;
  bqx_pkg::spin_vec_t  rd_j;
  bqx_pkg::spin_vec_t  si;
  bqx_pkg::spin_vec_t  sj;
  bqx_pkg::coup_t      rd_c;
  bqx_pkg::coup_t      jc;
  bqx_pkg::field_vec_t term;
  bqx_pkg::field_vec_t out_field;
  bqx_pkg::acc_ctrl_t  ctrl;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign atom_ok  = int'(atom_index) < MAX_ATOMS;
  assign nbr_ok   = int'(neighbour_index) < MAX_ATOMS;
  assign type_ok  = int'(type_index) < MAX_TYPES;
  assign pair_go  = accept && (action == bqx_pkg::ACT_PAIR);

  assign spin_wdata.x = spin_x;
  assign spin_wdata.y = spin_y;
  assign spin_wdata.z = spin_z;

  assign si = i_ok ? rd_i : '0;
  assign sj = j_ok ? rd_j : '0;
  assign jc = t_ok ? rd_c : '0;

  assign ctrl.fire = (state == ST_ACC) && (!last || !out_valid || out_ready);
  assign ctrl.last = last;
  assign ctrl.atom = atom;

  assign field_x = out_field.x;
  assign field_y = out_field.y;
  assign field_z = out_field.z;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pair_go) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cnt == 2'd0) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        if (ctrl.fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      if (pair_go) begin
        cnt <= 2'd3;
      end else if (state == ST_BUSY) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_go) begin
      i_ok <= atom_ok;
      j_ok <= nbr_ok;
      t_ok <= type_ok;
      last <= last_neighbour;
      atom <= atom_index;
    end
  end

  bqx_spin_store #(
    .MAX_ATOMS (MAX_ATOMS),
    .AW        (ATOM_AW)
  ) u_spin (
    .clk     (clk),
    .we      (accept && (action == bqx_pkg::ACT_SPIN) && atom_ok),
    .waddr   (ATOM_AW'(atom_index)),
    .wdata   (spin_wdata),
    .re      (pair_go),
    .raddr_a (ATOM_AW'(atom_index)),
    .raddr_b (ATOM_AW'(neighbour_index)),
    .rdata_a (rd_i),
    .rdata_b (rd_j)
  );

  bqx_coup_store #(
    .MAX_TYPES (MAX_TYPES),
    .AW        (TYPE_AW)
  ) u_coup (
    .clk   (clk),
    .we    (accept && (action == bqx_pkg::ACT_COUP) && type_ok),
    .waddr (TYPE_AW'(type_index)),
    .wdata (coupling),
    .re    (pair_go),
    .raddr (TYPE_AW'(type_index)),
    .rdata (rd_c)
  );

  bqx_term_pipe u_term (
    .clk  (clk),
    .si   (si),
    .sj   (sj),
    .jc   (jc),
    .term (term)
  );

  bqx_accum u_acc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .term      (term),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_atom  (field_atom),
    .out_field (out_field)
  );

endmodule

`default_nettype wire
